// ===== hw/rtl/egt_pkg.sv =====
// egt_pkg: widths and constants shared by the extremum gap tracker.
// No dependencies.
`timescale 1ns / 1ps

package egt_pkg;

    localparam int VALUE_BITS = 32;               // compared sample width
    localparam int INDEX_BITS = 16;               // sample index / gap width
    localparam int GAP_BITS   = 17;               // signed output gap width
    localparam int OUT_BITS   = 2 * GAP_BITS;     // packed result fields
    localparam int OUT_BYTES  = (OUT_BITS + 7) / 8;
    localparam int OUT_TDATA  = OUT_BYTES * 8;

    localparam logic [INDEX_BITS-1:0] IDX_MAX  = '1;
    localparam logic [GAP_BITS-1:0]   GAP_NONE = '1;   // -1: fewer than two extrema

    typedef logic [INDEX_BITS-1:0] t_index;
    typedef logic [GAP_BITS-1:0]   t_gap;

    typedef struct packed {
        t_gap max_gap;
        t_gap min_gap;
    } t_result;

endpackage

// ===== hw/rtl/extremum_gap_tracker.sv =====
// extremum_gap_tracker: finds strict local extrema in a sample stream and reports
// the smallest adjacent gap and the first-to-last span on the final sample.
// Depends on egt_pkg.
`timescale 1ns / 1ps

// Channel    | Dir | Handshake           | Payload
// -----------+-----+---------------------+------------------------------------------
// s_axis     | in  | tvalid / tready     | tdata[31:0] = sample, tlast = is_last
// m_axis     | out | tvalid / tready     | tdata[16:0] = min_gap, [33:17] = max_gap
//
// Throughput: one sample per cycle while tready is high. A sample is evaluated against
// the two previous samples in the same cycle it is accepted; the tracking state and, for
// a final sample, the result register (skid register if occupied) are written at that edge.
// Results go through a two-entry output buffer (result register plus skid register),
// so samples keep flowing while a result waits; tready drops only when both hold a
// result. Synchronous active-low reset clears tracking state and buffer valid flags.
module extremum_gap_tracker
    import egt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [31:0]           i_s_axis_tdata,   // [31:0] sample (signed)
    input  logic                  i_s_axis_tlast,   // is_last
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_TDATA-1:0]  o_m_axis_tdata    // [16:0] min_gap, [33:17] max_gap, rest 0
);

    // ------------------------------------------------------------------
    // Tracking state
    // ------------------------------------------------------------------
    logic signed [VALUE_BITS-1:0] r_older, n_older;
    logic signed [VALUE_BITS-1:0] r_newer, n_newer;
    t_index                       r_samples_seen, n_samples_seen;
    logic                         r_have_extremum, n_have_extremum;
    t_index                       r_first_idx, n_first_idx;
    t_index                       r_latest_idx, n_latest_idx;
    t_index                       r_smallest_gap, n_smallest_gap;
    logic                         r_have_gap, n_have_gap;

    // Output buffer
    logic    r_out_valid, r_skid_valid;
    t_result r_out, r_skid;

    logic                         s_accept;
    logic                         m_pop;
    logic                         push;
    logic signed [VALUE_BITS-1:0] cur;
    logic                         peak;
    t_index                       idx;
    t_index                       gap;
    t_index                       span;
    t_result                      new_res;

    assign o_s_axis_tready = !r_skid_valid;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign m_pop           = r_out_valid && i_m_axis_tready;
    assign push            = s_accept && i_s_axis_tlast;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA - OUT_BITS){1'b0}}, r_out};

    // ------------------------------------------------------------------
    // Per-sample evaluation: middle sample is an extremum when strictly
    // above or strictly below both neighbors.
    // ------------------------------------------------------------------
    always_comb begin
        cur  = signed'(i_s_axis_tdata[VALUE_BITS-1:0]);
        peak = (r_samples_seen[INDEX_BITS-1:1] != '0) &&
               (((r_newer > r_older) && (r_newer > cur)) ||
                ((r_newer < r_older) && (r_newer < cur)));
        idx  = r_samples_seen - t_index'(1);
        gap  = idx - r_latest_idx;

        n_have_extremum = r_have_extremum;
        n_first_idx     = r_first_idx;
        n_latest_idx    = r_latest_idx;
        n_smallest_gap  = r_smallest_gap;
        n_have_gap      = r_have_gap;

        if (peak) begin
            if (r_have_extremum) begin
                if (!r_have_gap || (gap < r_smallest_gap)) begin
                    n_smallest_gap = gap;
                end
                n_have_gap   = 1'b1;
                n_latest_idx = idx;
            end else begin
                n_first_idx     = idx;
                n_latest_idx    = idx;
                n_have_extremum = 1'b1;
            end
        end

        n_older = r_newer;
        n_newer = cur;
        // index saturates at its maximum
        n_samples_seen = (r_samples_seen != IDX_MAX) ? r_samples_seen + t_index'(1)
                                                     : r_samples_seen;

        span = n_latest_idx - n_first_idx;
        if (n_have_gap) begin
            new_res.min_gap = {{(GAP_BITS - INDEX_BITS){1'b0}}, n_smallest_gap};
            new_res.max_gap = {{(GAP_BITS - INDEX_BITS){1'b0}}, span};
        end else begin
            new_res.min_gap = GAP_NONE;
            new_res.max_gap = GAP_NONE;
        end
    end

    // Tracking registers; the final sample returns everything to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || push) begin
            r_older         <= '0;
            r_newer         <= '0;
            r_samples_seen  <= '0;
            r_have_extremum <= 1'b0;
            r_first_idx     <= '0;
            r_latest_idx    <= '0;
            r_smallest_gap  <= IDX_MAX;
            r_have_gap      <= 1'b0;
        end else if (s_accept) begin
            r_older         <= n_older;
            r_newer         <= n_newer;
            r_samples_seen  <= n_samples_seen;
            r_have_extremum <= n_have_extremum;
            r_first_idx     <= n_first_idx;
            r_latest_idx    <= n_latest_idx;
            r_smallest_gap  <= n_smallest_gap;
            r_have_gap      <= n_have_gap;
        end
    end

    // Output buffer: skid only fills while the result register is stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (m_pop) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else if (push) begin
                r_out <= new_res;
            end else begin
                r_out_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid) begin
                r_skid       <= new_res;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= new_res;
                r_out_valid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while result register is empty");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_samples_seen == '0 && !r_have_extremum && !r_have_gap))
        else $error("tracking state not cleared after final sample");

    a_gap_needs_extremum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_gap |-> r_have_extremum)
        else $error("gap recorded without a first extremum");

    a_gap_within_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have_gap |-> (r_smallest_gap <= (r_latest_idx - r_first_idx)))
        else $error("smallest gap exceeds first-to-last span");

    a_no_result_without_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !i_s_axis_tlast && !r_out_valid) |=> !o_m_axis_tvalid)
        else $error("result produced by a non-final sample");

endmodule
